// ----- hdl/sctb_pkg.sv -----
// Shared types, constants and the register FIS dword table of the command table builder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package sctb_pkg;

   localparam int MAX_TABLE_ENTRIES_DEF = 32;
   localparam int CHUNK_LIMIT_BYTES_DEF = 4194304;
   localparam int SECTOR_BYTES_DEF      = 512;

   // A request gives at most this many words: header, FIS and entries.
   localparam int MAX_RESULTS = 14;
   localparam int FIS_DWORDS  = 5;
   localparam int ENTRY_SLOTS = MAX_RESULTS - 1 - FIS_DWORDS;

   localparam int IDX_W     = 5;
   localparam int FLAGS_W   = 16;
   localparam int ECOUNT_W  = 6;
   localparam int BCOUNT_W  = 22;
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 152;

   localparam logic [7:0] FIS_TYPE_H2D   = 8'h27;
   localparam logic [7:0] FIS_CMD_BIT    = 8'h80;
   localparam logic [7:0] DEVICE_LBA_BIT = 8'h40;
   localparam logic [FLAGS_W-1:0] FLAGS_FIS_LEN = 16'd5;
   localparam logic [FLAGS_W-1:0] FLAGS_WRITE   = 16'h0040;

   typedef enum logic [2:0] {
      KIND_HEADER   = 3'd0,
      KIND_FIS      = 3'd1,
      KIND_ENTRY    = 3'd2,
      KIND_NO_DATA  = 3'd3,
      KIND_OVERFLOW = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COUNT,
      ST_HEADER,
      ST_FIS,
      ST_ENTRY
   } state_type;

   typedef struct packed {
      logic     load_req;
      logic     start_count;
      logic     count_step;
      logic     restart;
      logic     fis_step;
      logic     entry_step;
      logic     emit;
      kind_type kind;
      logic     last;
   } dp_cmd_type;

   typedef struct packed {
      logic bad_data;
      logic rem_zero;
      logic at_limit;
      logic fis_last;
      logic entries_zero;
      logic entry_final;
   } dp_status_type;

   function automatic logic [31:0] fis_dword(input logic [IDX_W-1:0] idx,
                                             input logic [7:0] code,
                                             input logic [47:0] lba,
                                             input logic [15:0] count);
      logic [31:0] dw;
      dw = 32'd0;
      case (idx)
         5'd0:    dw = {8'h00, code, FIS_CMD_BIT, FIS_TYPE_H2D};
         5'd1:    dw = {DEVICE_LBA_BIT, lba[23:0]};
         5'd2:    dw = {8'h00, lba[47:24]};
         5'd3:    dw = {16'h0000, count};
         default: dw = 32'd0;
      endcase
      return dw;
   endfunction

endpackage

// ----- hdl/sctb_datapath.sv -----
// Datapath of the command table builder: request and base registers, chunk arithmetic
// and the result word register. Depends on sctb_pkg; driven by sctb_controller.
`timescale 1ns / 1ps

module sctb_datapath #(
   parameter int MAX_TABLE_ENTRIES = sctb_pkg::MAX_TABLE_ENTRIES_DEF,
   parameter int CHUNK_LIMIT_BYTES = sctb_pkg::CHUNK_LIMIT_BYTES_DEF,
   parameter int SECTOR_BYTES      = sctb_pkg::SECTOR_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [63:0]                          csr_wr_data,
   input  logic [7:0]                           in_command_code,
   input  logic [47:0]                          in_block_address,
   input  logic [15:0]                          in_sector_count,
   input  logic [63:0]                          in_buffer_address,
   input  logic                                 in_is_write,
   input  logic                                 in_has_data,
   input  sctb_pkg::dp_cmd_type                 cmd,
   output sctb_pkg::dp_status_type              status,
   output sctb_pkg::kind_type                   out_item_kind,
   output logic [sctb_pkg::IDX_W-1:0]           out_word_index,
   output logic [sctb_pkg::FLAGS_W-1:0]         out_header_flags,
   output logic [sctb_pkg::ECOUNT_W-1:0]        out_entry_count,
   output logic [31:0]                          out_fis_dword,
   output logic [63:0]                          out_region_address,
   output logic [sctb_pkg::BCOUNT_W-1:0]        out_byte_count_minus_one,
   output logic                                 out_interrupt_on_done,
   output logic                                 out_last
);
   import sctb_pkg::*;

   localparam int TOTAL_W = 16 + $clog2(SECTOR_BYTES + 1);
   localparam int CHUNK_W = $clog2(CHUNK_LIMIT_BYTES + 1);
   localparam int REM_W   = (TOTAL_W > CHUNK_W) ? TOTAL_W : CHUNK_W;
   localparam int ENTRY_LIMIT = (MAX_TABLE_ENTRIES < ENTRY_SLOTS) ?
                                MAX_TABLE_ENTRIES : ENTRY_SLOTS;
   localparam int CNT_W = $clog2(ENTRY_LIMIT + 1);
   localparam logic [REM_W-1:0] CHUNK_LIM = REM_W'(CHUNK_LIMIT_BYTES);

   logic [7:0]       code_ff;
   logic [47:0]      lba_ff;
   logic [15:0]      count_ff;
   logic [63:0]      buf_ff;
   logic             wr_ff;
   logic             data_ff;
   logic [63:0]      base_ff;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] off_ff, off_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [REM_W-1:0] total;
   logic [REM_W-1:0] chunk;

   kind_type              kind_ff;
   logic [IDX_W-1:0]      widx_ff, widx_in;
   logic [FLAGS_W-1:0]    flags_ff, flags_in;
   logic [ECOUNT_W-1:0]   ecount_ff, ecount_in;
   logic [31:0]           dword_ff, dword_in;
   logic [63:0]           region_ff, region_in;
   logic [BCOUNT_W-1:0]   bcount_ff, bcount_in;
   logic                  irq_ff, irq_in;
   logic                  last_ff;

   assign total = REM_W'(count_ff) * REM_W'(SECTOR_BYTES);
   assign chunk = (rem_ff > CHUNK_LIM) ? CHUNK_LIM : rem_ff;

   assign status.bad_data     = data_ff && (count_ff == 16'd0 || buf_ff == 64'd0);
   assign status.rem_zero     = (rem_ff == '0);
   assign status.at_limit     = (cnt_ff == CNT_W'(ENTRY_LIMIT));
   assign status.fis_last     = (idx_ff == IDX_W'(FIS_DWORDS - 1));
   assign status.entries_zero = (cnt_ff == '0);
   assign status.entry_final  = (rem_ff <= CHUNK_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 64'd0;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         code_ff  <= in_command_code;
         lba_ff   <= in_block_address;
         count_ff <= in_sector_count;
         buf_ff   <= in_buffer_address;
         wr_ff    <= in_is_write;
         data_ff  <= in_has_data;
      end
   end

   always_comb begin
      rem_in = rem_ff;
      off_in = off_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (cmd.start_count) begin
         // Without a data phase there is nothing to count.
         rem_in = data_ff ? total : '0;
         cnt_in = '0;
      end
      if (cmd.count_step) begin
         rem_in = rem_ff - chunk;
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.restart) begin
         rem_in = total;
         off_in = '0;
         idx_in = '0;
      end
      if (cmd.fis_step) begin
         idx_in = status.fis_last ? '0 : idx_ff + 1'b1;
      end
      if (cmd.entry_step) begin
         rem_in = rem_ff - chunk;
         off_in = off_ff + chunk;
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      off_ff <= off_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
   end

   // Result word fields; everything a kind does not use stays zero.
   always_comb begin
      widx_in   = '0;
      flags_in  = '0;
      ecount_in = '0;
      dword_in  = '0;
      region_in = '0;
      bcount_in = '0;
      irq_in    = 1'b0;
      case (cmd.kind)
         KIND_HEADER: begin
            flags_in  = FLAGS_FIS_LEN | (wr_ff ? FLAGS_WRITE : '0);
            ecount_in = ECOUNT_W'(cnt_ff);
            region_in = base_ff;
         end
         KIND_FIS: begin
            widx_in  = idx_ff;
            dword_in = fis_dword(idx_ff, code_ff, lba_ff, count_ff);
         end
         KIND_ENTRY: begin
            widx_in   = idx_ff;
            region_in = buf_ff + 64'(off_ff);
            bcount_in = BCOUNT_W'(chunk - 1'b1);
            irq_in    = status.entry_final;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         kind_ff   <= cmd.kind;
         widx_ff   <= widx_in;
         flags_ff  <= flags_in;
         ecount_ff <= ecount_in;
         dword_ff  <= dword_in;
         region_ff <= region_in;
         bcount_ff <= bcount_in;
         irq_ff    <= irq_in;
         last_ff   <= cmd.last;
      end
   end

   assign out_item_kind            = kind_ff;
   assign out_word_index           = widx_ff;
   assign out_header_flags         = flags_ff;
   assign out_entry_count          = ecount_ff;
   assign out_fis_dword            = dword_ff;
   assign out_region_address       = region_ff;
   assign out_byte_count_minus_one = bcount_ff;
   assign out_interrupt_on_done    = irq_ff;
   assign out_last                 = last_ff;

endmodule

// ----- hdl/sctb_controller.sv -----
// Controller of the command table builder: request acceptance, the entry counting pass
// and the sequencing of result words. Depends on sctb_pkg; commands sctb_datapath.
`timescale 1ns / 1ps

module sctb_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  sctb_pkg::dp_status_type  status,
   output sctb_pkg::dp_cmd_type     cmd
);
   import sctb_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new word if it is empty or being emptied now.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.kind = KIND_HEADER;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.bad_data) begin
               if (out_free) begin
                  cmd.emit = 1'b1;
                  cmd.kind = KIND_NO_DATA;
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.start_count = 1'b1;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            // One chunk is counted per cycle; the count is zero without a data phase.
            if (status.rem_zero) begin
               state_in = ST_HEADER;
            end else if (status.at_limit) begin
               if (out_free) begin
                  cmd.emit = 1'b1;
                  cmd.kind = KIND_OVERFLOW;
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.count_step = 1'b1;
            end
         end
         ST_HEADER: begin
            if (out_free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_HEADER;
               cmd.restart = 1'b1;
               state_in    = ST_FIS;
            end
         end
         ST_FIS: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               cmd.kind     = KIND_FIS;
               cmd.last     = status.fis_last && status.entries_zero;
               cmd.fis_step = 1'b1;
               if (status.fis_last) begin
                  state_in = status.entries_zero ? ST_IDLE : ST_ENTRY;
               end
            end
         end
         ST_ENTRY: begin
            if (out_free) begin
               cmd.emit       = 1'b1;
               cmd.kind       = KIND_ENTRY;
               cmd.last       = status.entry_final;
               cmd.entry_step = 1'b1;
               if (status.entry_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

// ----- hdl/sata_command_table_builder.sv -----
// Top level of the command table builder: stream ports, field packing and the
// controller and datapath instances. Depends on sctb_pkg, sctb_controller, sctb_datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tdata (one disk command)
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata, rsp_tuser, rsp_tlast
//   csr      in         csr_wr_en              csr_wr_data (command table base)
//
// A request of E scatter entries (at most 8 with the defaults) goes through a check state,
// a counting pass over its chunks, then one word per cycle while rsp is not stalled.
// A request without data gives only the header and FIS words; one rejected for missing
// data gives a single word; an overflow is found after the counting pass reaches the limit.
// Reset clears the controller and the table base; no clearing pass is needed.
// A stalled rsp holds the sequencer; a new request is taken while the final word waits.
`timescale 1ns / 1ps

module sata_command_table_builder #(
   parameter int MAX_TABLE_ENTRIES = sctb_pkg::MAX_TABLE_ENTRIES_DEF,
   parameter int CHUNK_LIMIT_BYTES = sctb_pkg::CHUNK_LIMIT_BYTES_DEF,
   parameter int SECTOR_BYTES      = sctb_pkg::SECTOR_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [63:0]                       csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // command_code, block_address, sector_count, buffer_address, is_write, has_data
   input  logic [sctb_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // word_index, header_flags, entry_count, fis_dword, region_address,
   // byte_count_minus_one, interrupt_on_done
   output logic [sctb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // item_kind
   output logic [2:0]                        rsp_tuser,
   output logic                              rsp_tlast
);
   import sctb_pkg::*;

   dp_cmd_type          cmd;
   dp_status_type       status;
   kind_type            kind;
   logic [IDX_W-1:0]    word_index;
   logic [FLAGS_W-1:0]  header_flags;
   logic [ECOUNT_W-1:0] entry_count;
   logic [31:0]         fis_dword_w;
   logic [63:0]         region_address;
   logic [BCOUNT_W-1:0] byte_count_minus_one;
   logic                interrupt_on_done;

   sctb_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sctb_datapath #(
      .MAX_TABLE_ENTRIES (MAX_TABLE_ENTRIES),
      .CHUNK_LIMIT_BYTES (CHUNK_LIMIT_BYTES),
      .SECTOR_BYTES      (SECTOR_BYTES)
   ) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .csr_wr_en                (csr_wr_en),
      .csr_wr_data              (csr_wr_data),
      .in_command_code          (req_tdata[7:0]),
      .in_block_address         (req_tdata[55:8]),
      .in_sector_count          (req_tdata[71:56]),
      .in_buffer_address        (req_tdata[135:72]),
      .in_is_write              (req_tdata[136]),
      .in_has_data              (req_tdata[137]),
      .cmd                      (cmd),
      .status                   (status),
      .out_item_kind            (kind),
      .out_word_index           (word_index),
      .out_header_flags         (header_flags),
      .out_entry_count          (entry_count),
      .out_fis_dword            (fis_dword_w),
      .out_region_address       (region_address),
      .out_byte_count_minus_one (byte_count_minus_one),
      .out_interrupt_on_done    (interrupt_on_done),
      .out_last                 (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, interrupt_on_done, byte_count_minus_one, region_address,
                       fis_dword_w, entry_count, header_flags, word_index};
   assign rsp_tuser = 3'(kind);

endmodule

// ----- hdl/sctb_checker.sv -----
// Port-level checker for the command table builder and its bind to the top level.
// Depends on sctb_pkg and sata_command_table_builder.
`timescale 1ns / 1ps

module sctb_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [151:0] rsp_tdata,
   input logic [2:0]   rsp_tuser,
   input logic         rsp_tlast
);
   import sctb_pkg::*;

   // A stalled word stays on the bus unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // Mid-request no new command is taken.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request accepted while a table was being built");

   // A rejection is a request's only word.
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_NO_DATA || rsp_tuser == KIND_OVERFLOW)
      |-> rsp_tlast)
      else $error("rejection word not marked last");

   a_header_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_HEADER |-> !rsp_tlast)
      else $error("header word marked last");

   // The interrupt flag sits exactly on the final scatter entry.
   a_entry_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ENTRY |-> rsp_tdata[145] == rsp_tlast)
      else $error("interrupt flag and last disagree on a scatter entry");

endmodule

bind sata_command_table_builder sctb_checker u_sctb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- bench/tb.sv -----
// Self-checking bench for the command table builder: directed and random disk commands.
// Depends on sctb_pkg and sata_command_table_builder; a built-in predictor checks every word.
`timescale 1ns / 1ps

module tb;
   import sctb_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int SETTLE_LEN   = 30;
   localparam int RANDOM_ITEMS = 30;
   localparam int SHOWN_ERRORS = 10;
   localparam int SECTORS_PER_CHUNK = CHUNK_LIMIT_BYTES_DEF / SECTOR_BYTES_DEF;

   typedef enum logic {
      ROW_PREDICTED,
      ROW_REJECTED
   } row_check_type;

   typedef struct packed {
      row_check_type check;
      logic [7:0]    code;
      logic [47:0]   lba;
      logic [15:0]   count;
      logic [63:0]   buf_addr;
      logic          is_write;
      logic          has_data;
   } command_type;

   typedef struct packed {
      kind_type             kind;
      logic [IDX_W-1:0]     idx;
      logic [FLAGS_W-1:0]   flags;
      logic [ECOUNT_W-1:0]  ecount;
      logic [31:0]          dword;
      logic [63:0]          addr;
      logic [BCOUNT_W-1:0]  bcount;
      logic                 irq;
      logic                 last;
   } slot_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [63:0]           csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;

   slot_word_type slot_words_due[$];
   logic [63:0]   table_base = '0;
   int unsigned   mismatch_count = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   rsp_stall_pct = 0;

   // Directed commands: extremes, chunk boundaries and the missing-data rejections.
   command_type directed_rows [0:15] = '{
      '{ROW_PREDICTED, 8'h00, 48'h0, 16'd0, 64'h0, 1'b0, 1'b0},
      '{ROW_PREDICTED, 8'hFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        1'b1, 1'b0},
      '{ROW_REJECTED,  8'h25, 48'h0, 16'd0, 64'h1000, 1'b0, 1'b1},
      '{ROW_REJECTED,  8'h35, 48'h123, 16'd16, 64'h0, 1'b1, 1'b1},
      '{ROW_REJECTED,  8'hC8, 48'h0, 16'd0, 64'h0, 1'b0, 1'b1},
      '{ROW_REJECTED,  8'hFF, 48'hFFFF_FFFF_FFFF, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF,
        1'b1, 1'b1},
      '{ROW_PREDICTED, 8'h25, 48'h0, 16'd1, 64'h1, 1'b0, 1'b1},
      '{ROW_PREDICTED, 8'h35, 48'hFFFF_FFFF_FFFF, 16'd8192, 64'h1000, 1'b1, 1'b1},
      '{ROW_PREDICTED, 8'hC8, 48'hAAAA_AAAA_AAAA, 16'd8193, 64'h5555_5555_5555_5555,
        1'b0, 1'b1},
      '{ROW_PREDICTED, 8'hCA, 48'h5555_5555_5555, 16'd16384, 64'h2000_0000, 1'b1, 1'b1},
      '{ROW_PREDICTED, 8'h25, 48'h1, 16'd57344, 64'h1, 1'b0, 1'b1},
      '{ROW_PREDICTED, 8'h35, 48'h0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1},
      '{ROW_PREDICTED, 8'hEC, 48'h0, 16'd1, 64'h0, 1'b0, 1'b0},
      '{ROW_PREDICTED, 8'h60, 48'hFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFC0_0000, 1'b0, 1'b1},
      '{ROW_PREDICTED, 8'h61, 48'h100_0000, 16'd8191, 64'h8000_0000_0000_0000, 1'b1, 1'b1},
      '{ROW_PREDICTED, 8'hE7, 48'h0, 16'd0, 64'h0, 1'b0, 1'b0}
   };

   sata_command_table_builder u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) < rsp_stall_pct) ? 1'b0 : 1'b1;
   end

   // Works out the words that one command should produce: a rejection, or header, FIS and scatter words.
   function automatic void predict_slot(command_type c);
      int unsigned   total;
      int unsigned   entries;
      int unsigned   rem;
      int unsigned   chunk;
      logic [63:0]   offset;
      slot_word_type w;
      if (c.has_data && (c.count == 0 || c.buf_addr == 0)) begin
         w = '0;
         w.kind = KIND_NO_DATA;
         w.last = 1'b1;
         slot_words_due.push_back(w);
         return;
      end
      total   = int'(c.count) * SECTOR_BYTES_DEF;
      entries = c.has_data ? (total + CHUNK_LIMIT_BYTES_DEF - 1) / CHUNK_LIMIT_BYTES_DEF : 0;
      if (entries > MAX_TABLE_ENTRIES_DEF || entries > ENTRY_SLOTS) begin
         w = '0;
         w.kind = KIND_OVERFLOW;
         w.last = 1'b1;
         slot_words_due.push_back(w);
         return;
      end
      w = '0;
      w.kind   = KIND_HEADER;
      w.flags  = FLAGS_FIS_LEN | (c.is_write ? FLAGS_WRITE : '0);
      w.ecount = ECOUNT_W'(entries);
      w.addr   = table_base;
      slot_words_due.push_back(w);
      for (int i = 0; i < FIS_DWORDS; i++) begin
         w = '0;
         w.kind = KIND_FIS;
         w.idx  = IDX_W'(i);
         case (i)
            0: w.dword = {8'h00, c.code, FIS_CMD_BIT, FIS_TYPE_H2D};
            1: w.dword = {DEVICE_LBA_BIT, c.lba[23:0]};
            2: w.dword = {8'h00, c.lba[47:24]};
            3: w.dword = {16'h0000, c.count};
            default: w.dword = 32'd0;
         endcase
         w.last = (i == FIS_DWORDS - 1) && (entries == 0);
         slot_words_due.push_back(w);
      end
      rem    = total;
      offset = '0;
      for (int i = 0; i < int'(entries); i++) begin
         chunk    = (rem > CHUNK_LIMIT_BYTES_DEF) ? CHUNK_LIMIT_BYTES_DEF : rem;
         w        = '0;
         w.kind   = KIND_ENTRY;
         w.idx    = IDX_W'(i);
         w.addr   = c.buf_addr + offset;
         w.bcount = BCOUNT_W'(chunk - 1);
         w.irq    = (rem == chunk);
         w.last   = (rem == chunk);
         slot_words_due.push_back(w);
         rem    -= chunk;
         offset += 64'(chunk);
      end
   endfunction

   // Mostly valid data commands, with counts near chunk boundaries and a little noise.
   function automatic command_type random_command();
      command_type c;
      logic [31:0] lo;
      logic [31:0] hi;
      int unsigned pick;
      c       = '0;
      c.check = ROW_PREDICTED;
      c.code  = 8'($urandom_range(255));
      lo      = $urandom;
      hi      = $urandom;
      c.lba   = {hi[15:0], lo};
      pick    = $urandom_range(9);
      if (pick <= 2)
         c.count = 16'($urandom_range(1, 16));
      else if (pick <= 5)
         c.count = 16'($urandom_range(1, 7) * SECTORS_PER_CHUNK + $urandom_range(2) - 1);
      else if (pick == 6)
         c.count = 16'($urandom_range(57344, 65535));
      else if (pick <= 8)
         c.count = 16'($urandom_range(1, 65535));
      else
         c.count = 16'd0;
      lo   = $urandom;
      hi   = $urandom;
      pick = $urandom_range(9);
      if (pick == 0)
         c.buf_addr = '0;
      else if (pick == 1)
         c.buf_addr = {32'hFFFF_FFFF, 8'hFF, lo[23:0]};
      else
         c.buf_addr = {hi, lo};
      c.is_write = 1'($urandom_range(1));
      c.has_data = ($urandom_range(9) != 0);
      return c;
   endfunction

   task automatic send_command(command_type c);
      slot_word_type w;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, c.has_data, c.is_write, c.buf_addr, c.count, c.lba, c.code};
      do @(posedge clock); while (!req_tready);
      if (c.check == ROW_REJECTED) begin
         w      = '0;
         w.kind = KIND_NO_DATA;
         w.last = 1'b1;
         slot_words_due.push_back(w);
      end else begin
         predict_slot(c);
      end
   endtask

   task automatic sender_gap();
      int unsigned n;
      n = 0;
      while ($urandom_range(99) < send_idle_pct) n++;
      if (n > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain_slots();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (slot_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_LEN) @(posedge clock);
   endtask

   task automatic write_table_base(logic [63:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      table_base = value;
   endtask

   task automatic note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS) $display("%t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      slot_word_type got;
      slot_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind   = kind_type'(rsp_tuser);
         got.idx    = rsp_tdata[4:0];
         got.flags  = rsp_tdata[20:5];
         got.ecount = rsp_tdata[26:21];
         got.dword  = rsp_tdata[58:27];
         got.addr   = rsp_tdata[122:59];
         got.bcount = rsp_tdata[144:123];
         got.irq    = rsp_tdata[145];
         got.last   = rsp_tlast;
         if (slot_words_due.size() == 0) begin
            note_mismatch($sformatf("unexpected word kind=%0d idx=%0d", got.kind, got.idx));
         end else begin
            want = slot_words_due.pop_front();
            if (got !== want)
               note_mismatch($sformatf(
                  {"word mismatch: exp kind=%0d idx=%0d flags=%h cnt=%0d dw=%h addr=%h ",
                   "bc=%h irq=%b last=%b / got kind=%0d idx=%0d flags=%h cnt=%0d dw=%h ",
                   "addr=%h bc=%h irq=%b last=%b"},
                  want.kind, want.idx, want.flags, want.ecount, want.dword, want.addr,
                  want.bcount, want.irq, want.last, got.kind, got.idx, got.flags,
                  got.ecount, got.dword, got.addr, got.bcount, got.irq, got.last));
         end
      end
   end

   initial begin
      logic [63:0] bases [4];
      int unsigned send_pcts [4];
      int unsigned stall_pcts [4];
      bases      = '{64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom}, 64'h0, {$urandom, $urandom}};
      send_pcts  = '{0, 57, 0, 32};
      stall_pcts = '{0, 0, 57, 32};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The directed rows run on the table base left by reset.
      foreach (directed_rows[i]) send_command(directed_rows[i]);
      drain_slots();

      for (int p = 0; p < 4; p++) begin
         write_table_base(bases[p]);
         send_idle_pct = send_pcts[p];
         rsp_stall_pct = stall_pcts[p];
         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sender_gap();
            send_command(random_command());
         end
         drain_slots();
      end

      if (mismatch_count == 0 && slot_words_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
